### design/optp_pkg.sv
`default_nettype none

package optp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 15;
  localparam int NS_W      = 3;
  localparam int LANES     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STREAMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PILOT_LEVEL = 1'b1;

  // tone plan of one 56-tone symbol
  localparam logic [5:0] TONE_FIRST = 6'd0;
  localparam logic [5:0] TONE_LAST  = 6'd55;
  localparam logic [5:0] TONE_P0    = 6'd7;
  localparam logic [5:0] TONE_P1    = 6'd21;
  localparam logic [5:0] TONE_P2    = 6'd34;
  localparam logic [5:0] TONE_P3    = 6'd48;

  localparam logic [6:0] POL_START = 7'd2;
  localparam logic [6:0] POL_LAST  = 7'd126;

  // pilot polarity sequence, 1 is +1, 0 is -1, element 0 leftmost
  localparam logic [0:126] POLARITY = {
    8'b11110001, 8'b00001101, 8'b00110110, 8'b11111101,
    8'b11011001, 8'b11010001, 8'b01001001, 8'b11110011,
    8'b00101011, 8'b00011000, 8'b01001011, 8'b11010101,
    8'b00000101, 8'b10101110, 8'b01000111, 7'b0000000
  };

  // pilot pattern [streams-1][stream][column], 1 is +1, 0 is -1
  localparam logic [0:3] PATTERN [4][4] = '{
    '{4'b1110, 4'b0000, 4'b0000, 4'b0000},
    '{4'b1100, 4'b1001, 4'b0000, 4'b0000},
    '{4'b1100, 4'b1010, 4'b0110, 4'b0000},
    '{4'b1110, 4'b1101, 4'b1011, 4'b0111}
  };

  // per-item control from the tone sequencer to the lanes
  typedef struct packed {
    logic       is_pilot;
    logic [1:0] pilot_col;
    logic       pol_bit;
    logic       eos_data;
  } ctrl_t;

  // what one lane produces for one item
  typedef struct packed {
    sample_t pilot_re;
    sample_t data_re;
    sample_t data_im;
  } lane_t;

  // one output beat
  typedef struct packed {
    sample_t [LANES-1:0] re;
    sample_t [LANES-1:0] im;
    logic                is_pilot;
    logic                eos;
    logic                eor;
  } beat_t;

endpackage

`default_nettype wire

### design/optp_ctrl.sv
`default_nettype none

module optp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            first_of_packet,
  output optp_pkg::ctrl_t ctrl
);
  import optp_pkg::*;

  logic [5:0] tone_r, tone_nxt;
  logic [6:0] pol_r, pol_nxt;
  logic [1:0] phase_r, phase_nxt;

  logic [5:0] tone_e;
  logic [6:0] pol_e;
  logic [1:0] phase_e;
  logic [5:0] data_tone;
  logic       pilot;
  logic [1:0] pilot_num;

  // packet restart puts this item on tone 0 of symbol 0
  always_comb begin
    tone_e  = first_of_packet ? TONE_FIRST : tone_r;
    pol_e   = first_of_packet ? POL_START  : pol_r;
    phase_e = first_of_packet ? 2'd0       : phase_r;
  end

  // pilot tone detect
  always_comb begin
    pilot     = 1'b1;
    pilot_num = 2'd0;
    case (tone_e)
      TONE_P0: pilot_num = 2'd0;
      TONE_P1: pilot_num = 2'd1;
      TONE_P2: pilot_num = 2'd2;
      TONE_P3: pilot_num = 2'd3;
      default: pilot = 1'b0;
    endcase
  end

  assign data_tone = tone_e + {5'd0, pilot};

  always_comb begin
    ctrl.is_pilot  = pilot;
    ctrl.pilot_col = phase_e + pilot_num;
    ctrl.pol_bit   = POLARITY[pol_e];
    ctrl.eos_data  = (data_tone == TONE_LAST);
  end

  // advance past the data tone, wrapping at the symbol end
  always_comb begin
    tone_nxt  = tone_r;
    pol_nxt   = pol_r;
    phase_nxt = phase_r;
    if (in_fire) begin
      if (data_tone == TONE_LAST) begin
        tone_nxt  = TONE_FIRST;
        phase_nxt = phase_e + 2'd1;
        pol_nxt   = (pol_e == POL_LAST) ? 7'd0 : pol_e + 7'd1;
      end else begin
        tone_nxt  = data_tone + 6'd1;
        phase_nxt = phase_e;
        pol_nxt   = pol_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r  <= TONE_FIRST;
      pol_r   <= POL_START;
      phase_r <= 2'd0;
    end else begin
      tone_r  <= tone_nxt;
      pol_r   <= pol_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

### design/optp_lane.sv
`default_nettype none

module optp_lane (
  input  logic                          [1:0] lane_id,
  input  logic        [optp_pkg::NS_W-1:0]    ns_eff,
  input  optp_pkg::ctrl_t                     ctrl,
  input  logic     [optp_pkg::LEVEL_W-1:0]    level,
  input  optp_pkg::sample_t                   din_re,
  input  optp_pkg::sample_t                   din_im,
  output optp_pkg::lane_t                     lane_out
);
  import optp_pkg::*;

  logic          en;
  logic [1:0]    tbl;
  logic          pat;
  logic          pos;
  sample_t       lvl;

  // stream enable and pattern entry for this lane
  assign en  = ({1'b0, lane_id} < ns_eff);
  assign tbl = 2'(ns_eff - 3'd1);
  assign pat = PATTERN[tbl][lane_id][ctrl.pilot_col];
  assign pos = ~(ctrl.pol_bit ^ pat);
  assign lvl = sample_t'({1'b0, level});

  // pilot and data values, zero on disabled streams
  always_comb begin
    lane_out.pilot_re = '0;
    lane_out.data_re  = '0;
    lane_out.data_im  = '0;
    if (en) begin
      lane_out.pilot_re = pos ? lvl : sample_t'(0) - lvl;
      lane_out.data_re  = din_re;
      lane_out.data_im  = din_im;
    end
  end

endmodule

`default_nettype wire

### design/ofdm_pilot_tone_insertion.sv
`default_nettype none

// channel | direction | handshake        | payload
// in      | input     | in_valid/ready   | first_of_packet, four streams of re/im
// out     | output    | out_valid/ready  | four streams of re/im, is_pilot, eos, eor
// cfg     | input     | cfg_wr_en        | cfg_index, cfg_wdata (no read-back)
//
// one beat in per cycle on data tones while out_ready is high; results are
// registered and leave in the cycle after acceptance; an item on a pilot slot
// gives two beats, the pilot then its data; the second beat sits in a pending
// register, input waiting until it moves out; a 56-tone symbol takes 52 input beats
// synchronous active-low reset: tone 0, polarity index 2, one stream, level 1.0
// output register holds while out_ready is low; input is taken only into a free slot

module ofdm_pilot_tone_insertion (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [optp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [optp_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_first_of_packet,
  input  optp_pkg::sample_t                     in_s0_re,
  input  optp_pkg::sample_t                     in_s0_im,
  input  optp_pkg::sample_t                     in_s1_re,
  input  optp_pkg::sample_t                     in_s1_im,
  input  optp_pkg::sample_t                     in_s2_re,
  input  optp_pkg::sample_t                     in_s2_im,
  input  optp_pkg::sample_t                     in_s3_re,
  input  optp_pkg::sample_t                     in_s3_im,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output optp_pkg::sample_t                     out_o0_re,
  output optp_pkg::sample_t                     out_o0_im,
  output optp_pkg::sample_t                     out_o1_re,
  output optp_pkg::sample_t                     out_o1_im,
  output optp_pkg::sample_t                     out_o2_re,
  output optp_pkg::sample_t                     out_o2_im,
  output optp_pkg::sample_t                     out_o3_re,
  output optp_pkg::sample_t                     out_o3_im,
  output logic                                  out_is_pilot,
  output logic                                  out_end_of_symbol,
  output logic                                  out_end_of_run
);
  import optp_pkg::*;

  logic [NS_W-1:0]    ns_r;
  logic [LEVEL_W-1:0] level_r;
  logic [NS_W-1:0]    ns_eff;

  ctrl_t   ctrl;
  lane_t   lane_res [LANES];
  sample_t din_re [LANES];
  sample_t din_im [LANES];

  logic  out_valid_r, out_valid_nxt;
  beat_t out_r, out_nxt;
  logic  pend_r, pend_nxt;
  beat_t pend_beat_r, pend_beat_nxt;
  beat_t pilot_beat, data_beat;

  logic in_fire;
  logic slot_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r    <= NS_W'(1);
      level_r <= LEVEL_W'(16384);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_STREAMS: ns_r    <= cfg_wdata[NS_W-1:0];
        CFG_PILOT_LEVEL: level_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero streams acts as one, above four acts as four
  always_comb begin
    ns_eff = ns_r;
    if (ns_r == NS_W'(0)) ns_eff = NS_W'(1);
    else if (ns_r > NS_W'(4)) ns_eff = NS_W'(4);
  end

  assign slot_free = ~out_valid_r | out_ready;
  assign in_ready  = slot_free & ~pend_r;
  assign in_fire   = in_valid & in_ready;

  optp_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .first_of_packet (in_first_of_packet),
    .ctrl            (ctrl)
  );

  assign din_re[0] = in_s0_re;
  assign din_im[0] = in_s0_im;
  assign din_re[1] = in_s1_re;
  assign din_im[1] = in_s1_im;
  assign din_re[2] = in_s2_re;
  assign din_im[2] = in_s2_im;
  assign din_re[3] = in_s3_re;
  assign din_im[3] = in_s3_im;

  // one lane per space-time stream
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    optp_lane u_lane (
      .lane_id  (2'(g)),
      .ns_eff   (ns_eff),
      .ctrl     (ctrl),
      .level    (level_r),
      .din_re   (din_re[g]),
      .din_im   (din_im[g]),
      .lane_out (lane_res[g])
    );
  end

  // merge lane results into pilot and data beats
  always_comb begin
    pilot_beat.is_pilot = 1'b1;
    pilot_beat.eos      = 1'b0;
    pilot_beat.eor      = 1'b0;
    data_beat.is_pilot  = 1'b0;
    data_beat.eos       = ctrl.eos_data;
    data_beat.eor       = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      pilot_beat.re[i] = lane_res[i].pilot_re;
      pilot_beat.im[i] = '0;
      data_beat.re[i]  = lane_res[i].data_re;
      data_beat.im[i]  = lane_res[i].data_im;
    end
  end

  // output register and pending data beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_beat_nxt = pend_beat_r;
    if (pend_r && slot_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_beat_r;
      pend_nxt      = 1'b0;
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (ctrl.is_pilot) begin
        out_nxt       = pilot_beat;
        pend_nxt      = 1'b1;
        pend_beat_nxt = data_beat;
      end else begin
        out_nxt = data_beat;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    pend_beat_r <= pend_beat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_o0_re         = out_r.re[0];
  assign out_o0_im         = out_r.im[0];
  assign out_o1_re         = out_r.re[1];
  assign out_o1_im         = out_r.im[1];
  assign out_o2_re         = out_r.re[2];
  assign out_o2_im         = out_r.im[2];
  assign out_o3_re         = out_r.re[3];
  assign out_o3_im         = out_r.im[3];
  assign out_is_pilot      = out_r.is_pilot;
  assign out_end_of_symbol = out_r.eos;
  assign out_end_of_run    = out_r.eor;

endmodule

`default_nettype wire

### design/optp_chk.sv
`default_nettype none

module optp_chk (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input wire optp_pkg::sample_t               out_o0_re,
  input wire optp_pkg::sample_t               out_o0_im,
  input wire optp_pkg::sample_t               out_o1_im,
  input wire optp_pkg::sample_t               out_o2_im,
  input wire optp_pkg::sample_t               out_o3_im,
  input wire                                  out_is_pilot,
  input wire                                  out_end_of_symbol,
  input wire                                  out_end_of_run
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a pilot beat never closes an item's run, a data beat always does
  a_run_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_of_run != out_is_pilot))
    else $error("end_of_run does not match beat kind");

  // pilots carry no quadrature part and never sit on the last tone
  a_pilot_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_pilot) |->
      (out_o0_im == 0 && out_o1_im == 0 && out_o2_im == 0 && out_o3_im == 0
       && !out_end_of_symbol))
    else $error("malformed pilot beat");

  // the data beat of a pilot item follows right after the pilot is taken
  a_pilot_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_is_pilot) |=> (out_valid && !out_is_pilot))
    else $error("data beat missing after pilot");

  // stalled output beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_o0_re)
      && $stable(out_is_pilot)))
    else $error("output changed under stall");

endmodule

bind ofdm_pilot_tone_insertion optp_chk u_optp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_o0_re         (out_o0_re),
  .out_o0_im         (out_o0_im),
  .out_o1_im         (out_o1_im),
  .out_o2_im         (out_o2_im),
  .out_o3_im         (out_o3_im),
  .out_is_pilot      (out_is_pilot),
  .out_end_of_symbol (out_end_of_symbol),
  .out_end_of_run    (out_end_of_run)
);

`default_nettype wire
